// ===== rtl/core/sbps_pkg.sv =====
// Shared types, constants and helpers for the servo bus ping scanner.
package sbps_pkg;

   localparam int unsigned IdW      = 8;
   localparam int unsigned ByteW    = 8;
   localparam int unsigned TimeoutW = 16;
   localparam int unsigned QuietW   = 17;
   localparam int unsigned CountW   = 3;
   localparam int unsigned BeatW    = 3;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned ReplyLen = 5;

   localparam logic [ByteW-1:0]    HDR           = 8'hFF;
   localparam logic [ByteW-1:0]    PING_LEN      = 8'h02;
   localparam logic [ByteW-1:0]    PING_INST     = 8'h01;
   localparam logic [QuietW-1:0]   QUIET_MAX     = 17'h1FFFF;
   localparam logic [IdW-1:0]      FOUND_MAX     = 8'hFF;
   localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd4000;
   localparam logic [IdW-1:0]      MAX_ID_RESET  = 8'd253;
   localparam logic [CountW-1:0]   REPLY_LAST    = 3'd5;

   localparam logic [CsrIdxW-1:0] CSR_REPLY_TIMEOUT = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_ID        = 2'd1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_BYTE  = 2'd1,
      OP_START = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_TX      = 2'd0,
      KIND_OUTCOME = 2'd1,
      KIND_DONE    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BURST_PING     = 2'd0,
      BURST_OUT_PING = 2'd1,
      BURST_OUT_DONE = 2'd2
   } burst_type;

   typedef struct packed {
      burst_type          burst;
      logic [IdW-1:0]     out_id;
      logic [IdW-1:0]     ping_id;
      logic               present;
      logic [IdW-1:0]     found;
   } desc_type;

   typedef struct packed {
      logic     load;
      desc_type desc;
   } load_type;

   typedef struct packed {
      logic free;
   } status_type;

   function automatic logic [ByteW-1:0] ping_byte(input logic [IdW-1:0] id,
                                                  input logic [BeatW-1:0] idx);
      logic [ByteW-1:0] b;
      case (idx)
         3'd0:    b = HDR;
         3'd1:    b = HDR;
         3'd2:    b = id;
         3'd3:    b = PING_LEN;
         3'd4:    b = PING_INST;
         default: b = ~(id + PING_LEN + PING_INST);
      endcase
      return b;
   endfunction

   function automatic logic [BeatW-1:0] last_beat(input burst_type b);
      logic [BeatW-1:0] n;
      case (b)
         BURST_PING:     n = 3'd5;
         BURST_OUT_PING: n = 3'd6;
         BURST_OUT_DONE: n = 3'd1;
         default:        n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/sbps_req_if.sv =====
// Request channel: one input beat carries an op and a received byte.
interface sbps_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               op;
   logic [sbps_pkg::ByteW-1:0] rx_byte;

   modport source(output valid, op, rx_byte, input ready);
   modport sink(input valid, op, rx_byte, output ready);
endinterface

// ===== rtl/core/sbps_rsp_if.sv =====
// Response channel: one result beat of the scanner.
interface sbps_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 kind;
   logic [sbps_pkg::ByteW-1:0] tx_byte;
   logic [sbps_pkg::IdW-1:0]   servo_id;
   logic                       present;
   logic [sbps_pkg::IdW-1:0]   found_count;
   logic                       last;

   modport source(output valid, kind, tx_byte, servo_id, present, found_count, last,
                  input ready);
   modport sink(input valid, kind, tx_byte, servo_id, present, found_count, last,
                output ready);
endinterface

// ===== rtl/core/sbps_csr_if.sv =====
// Configuration write channel: register index and write data.
interface sbps_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sbps_pkg::CsrIdxW-1:0]  index;
   logic [sbps_pkg::CsrDataW-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/servo_bus_ping_scanner_top.sv =====
// Servo bus ping scanner: input register, then result register, then result beats.
// An item with no result (most ticks, idle bytes) passes at one item per cycle.
// An item with results holds the result register for 2, 6 or 7 output beats; the
// next item waits in the input register only if it also produces results.
// Reset clears the scan state and loads reply_timeout 4000 and max_id 253.
module servo_bus_ping_scanner_top (
   input  logic       clock,
   input  logic       reset,
   sbps_req_if.sink   req_bus,
   sbps_rsp_if.source rsp_bus,
   sbps_csr_if.sink   csr_bus
);

   logic [sbps_pkg::TimeoutW-1:0] timeout_ff;
   logic [sbps_pkg::IdW-1:0]      max_id_ff;
   sbps_pkg::load_type            load;
   sbps_pkg::status_type          status;
   logic [sbps_pkg::ByteW-1:0]    chk_expect;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sbps_pkg::TIMEOUT_RESET;
         max_id_ff  <= sbps_pkg::MAX_ID_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            sbps_pkg::CSR_REPLY_TIMEOUT: timeout_ff <= csr_bus.data;
            sbps_pkg::CSR_MAX_ID:        max_id_ff  <= csr_bus.data[sbps_pkg::IdW-1:0];
            default: begin
            end
         endcase
      end
   end

   sbps_scan_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .reply_timeout (timeout_ff),
      .max_id        (max_id_ff),
      .out_status    (status),
      .out_load      (load)
   );

   sbps_burst_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_load    (load),
      .out_status (status),
      .rsp_bus    (rsp_bus)
   );

   assign chk_expect = ~(rsp_bus.servo_id + sbps_pkg::PING_LEN + sbps_pkg::PING_INST);

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind == sbps_pkg::KIND_DONE) |-> rsp_bus.last)
      else $error("done beat not marked last");

   a_outcome_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind == sbps_pkg::KIND_OUTCOME) |-> !rsp_bus.last)
      else $error("outcome beat marked last");

   a_ping_checksum: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind == sbps_pkg::KIND_TX) && rsp_bus.last
      |-> rsp_bus.tx_byte == chk_expect)
      else $error("ping checksum beat mismatch");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load.load |-> status.free)
      else $error("burst loaded over a pending burst");

endmodule

// ===== rtl/core/sbps_scan_core.sv =====
// Input register and scan state update; hands at most one result burst descriptor per item.
module sbps_scan_core (
   input  logic                            clock,
   input  logic                            reset,
   sbps_req_if.sink                        req_bus,
   input  logic [sbps_pkg::TimeoutW-1:0]   reply_timeout,
   input  logic [sbps_pkg::IdW-1:0]        max_id,
   input  sbps_pkg::status_type            out_status,
   output sbps_pkg::load_type              out_load
);

   logic                         in_valid_ff, in_valid_in;
   logic [1:0]                   in_op_ff;
   logic [sbps_pkg::ByteW-1:0]   in_byte_ff;

   logic                         scanning_ff, scanning_in;
   logic [sbps_pkg::IdW-1:0]     cur_id_ff, cur_id_in;
   logic [sbps_pkg::CountW-1:0]  reply_count_ff, reply_count_in;
   logic [sbps_pkg::QuietW-1:0]  quiet_ff, quiet_in;
   logic [sbps_pkg::IdW-1:0]     found_ff, found_in;
   logic [sbps_pkg::ByteW-1:0]   reply_ff [sbps_pkg::ReplyLen];

   logic                         advance;
   logic                         take;
   logic                         emit;
   logic                         finish;
   logic                         ok;
   logic                         reply_wr;
   logic [sbps_pkg::QuietW-1:0]  quiet_inc;
   logic [sbps_pkg::ByteW-1:0]   sum;
   logic                         reply_ok;
   logic [sbps_pkg::IdW-1:0]     found_new;
   sbps_pkg::desc_type           desc;

   assign quiet_inc = (quiet_ff == sbps_pkg::QUIET_MAX) ? quiet_ff
                                                         : quiet_ff + 17'd1;
   assign sum       = reply_ff[2] + reply_ff[3] + reply_ff[4];
   assign reply_ok  = (reply_ff[0] == sbps_pkg::HDR) && (reply_ff[1] == sbps_pkg::HDR) &&
                      (reply_ff[2] == cur_id_ff) && (~sum == in_byte_ff);

   always_comb begin
      scanning_in    = scanning_ff;
      cur_id_in      = cur_id_ff;
      reply_count_in = reply_count_ff;
      quiet_in       = quiet_ff;
      found_in       = found_ff;
      emit           = 1'b0;
      finish         = 1'b0;
      ok             = 1'b0;
      reply_wr       = 1'b0;
      found_new      = found_ff;
      desc.burst     = sbps_pkg::BURST_PING;
      desc.out_id    = cur_id_ff;
      desc.ping_id   = cur_id_ff;
      desc.present   = 1'b0;
      desc.found     = found_ff;

      case (in_op_ff)
         sbps_pkg::OP_START: begin
            if (!scanning_ff) begin
               emit           = 1'b1;
               scanning_in    = 1'b1;
               cur_id_in      = '0;
               found_in       = '0;
               reply_count_in = '0;
               quiet_in       = '0;
               desc.ping_id   = '0;
               desc.out_id    = '0;
               desc.found     = '0;
            end
         end
         sbps_pkg::OP_TICK: begin
            if (scanning_ff) begin
               quiet_in = quiet_inc;
               if (quiet_inc > {1'b0, reply_timeout}) begin
                  finish = 1'b1;
               end
            end
         end
         sbps_pkg::OP_BYTE: begin
            if (scanning_ff) begin
               quiet_in = '0;
               if (reply_count_ff < sbps_pkg::REPLY_LAST) begin
                  reply_wr       = 1'b1;
                  reply_count_in = reply_count_ff + 3'd1;
               end else begin
                  finish = 1'b1;
                  ok     = reply_ok;
               end
            end
         end
         default: begin
         end
      endcase

      if (finish) begin
         emit = 1'b1;
         if (ok && (found_ff != sbps_pkg::FOUND_MAX)) begin
            found_new = found_ff + 8'd1;
         end
         found_in       = found_new;
         reply_count_in = '0;
         quiet_in       = '0;
         desc.present   = ok;
         desc.found     = found_new;
         if (cur_id_ff < max_id) begin
            cur_id_in    = cur_id_ff + 8'd1;
            desc.burst   = sbps_pkg::BURST_OUT_PING;
            desc.ping_id = cur_id_ff + 8'd1;
         end else begin
            scanning_in = 1'b0;
            desc.burst  = sbps_pkg::BURST_OUT_DONE;
         end
      end
   end

   assign advance       = in_valid_ff && (out_status.free || !emit);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;
   assign in_valid_in   = take || (in_valid_ff && !advance);

   assign out_load.load = advance && emit;
   assign out_load.desc = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         scanning_ff    <= 1'b0;
         cur_id_ff      <= '0;
         reply_count_ff <= '0;
         quiet_ff       <= '0;
         found_ff       <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            scanning_ff    <= scanning_in;
            cur_id_ff      <= cur_id_in;
            reply_count_ff <= reply_count_in;
            quiet_ff       <= quiet_in;
            found_ff       <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_bus.op;
         in_byte_ff <= req_bus.rx_byte;
      end
      if (advance && reply_wr) begin
         reply_ff[reply_count_ff] <= in_byte_ff;
      end
   end

endmodule

// ===== rtl/core/sbps_burst_out.sv =====
// Result register and beat sequencer that plays out one burst of results.
module sbps_burst_out (
   input  logic                  clock,
   input  logic                  reset,
   input  sbps_pkg::load_type    in_load,
   output sbps_pkg::status_type  out_status,
   sbps_rsp_if.source            rsp_bus
);

   logic                         burst_valid_ff;
   sbps_pkg::desc_type           desc_ff;
   logic [sbps_pkg::BeatW-1:0]   beat_ff;
   logic                         fire;
   logic                         end_beat;

   assign fire            = rsp_bus.valid && rsp_bus.ready;
   assign end_beat        = beat_ff == sbps_pkg::last_beat(desc_ff.burst);
   assign out_status.free = !burst_valid_ff || (fire && end_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_valid_ff <= 1'b0;
         beat_ff        <= '0;
      end else if (in_load.load) begin
         burst_valid_ff <= 1'b1;
         beat_ff        <= '0;
      end else if (fire) begin
         if (end_beat) begin
            burst_valid_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load.load) begin
         desc_ff <= in_load.desc;
      end
   end

   always_comb begin
      rsp_bus.valid       = burst_valid_ff;
      rsp_bus.found_count = desc_ff.found;
      rsp_bus.last        = end_beat;
      rsp_bus.kind        = sbps_pkg::KIND_TX;
      rsp_bus.tx_byte     = '0;
      rsp_bus.servo_id    = desc_ff.out_id;
      rsp_bus.present     = 1'b0;
      case (desc_ff.burst)
         sbps_pkg::BURST_PING: begin
            rsp_bus.tx_byte  = sbps_pkg::ping_byte(desc_ff.ping_id, beat_ff);
            rsp_bus.servo_id = desc_ff.ping_id;
         end
         sbps_pkg::BURST_OUT_PING: begin
            if (beat_ff == 3'd0) begin
               rsp_bus.kind    = sbps_pkg::KIND_OUTCOME;
               rsp_bus.present = desc_ff.present;
            end else begin
               rsp_bus.tx_byte  = sbps_pkg::ping_byte(desc_ff.ping_id, beat_ff - 3'd1);
               rsp_bus.servo_id = desc_ff.ping_id;
            end
         end
         sbps_pkg::BURST_OUT_DONE: begin
            if (beat_ff == 3'd0) begin
               rsp_bus.kind    = sbps_pkg::KIND_OUTCOME;
               rsp_bus.present = desc_ff.present;
            end else begin
               rsp_bus.kind = sbps_pkg::KIND_DONE;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the servo bus ping scanner: directed sweeps, extremes, random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          STALL_LIMIT  = 5000;
   localparam int          DRAIN_CYCLES = 4;
   localparam int          TAIL_CYCLES  = 10;
   localparam int          RANDOM_ITEMS = 30;
   localparam int          NO_FLIP      = 6;
   localparam int          PRINT_CAP    = 40;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [sbps_pkg::CsrIdxW-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sbps_pkg::CsrIdxW-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      sbps_pkg::kind_type         kind;
      logic [sbps_pkg::ByteW-1:0] tx_byte;
      logic [sbps_pkg::IdW-1:0]   servo_id;
      logic                       present;
      logic [sbps_pkg::IdW-1:0]   found_count;
      logic                       last;
   } scan_beat_type;

   logic clock;
   logic reset;

   sbps_req_if req_if();
   sbps_rsp_if rsp_if();
   sbps_csr_if csr_if();

   servo_bus_ping_scanner_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   scan_beat_type pending_beats[$];

   logic [sbps_pkg::TimeoutW-1:0] timeout_cfg;
   logic [sbps_pkg::IdW-1:0]      max_id_cfg;
   logic                          scanning;
   logic [sbps_pkg::IdW-1:0]      cur_id;
   logic [sbps_pkg::CountW-1:0]   reply_cnt;
   logic [sbps_pkg::QuietW-1:0]   quiet_ticks;
   logic [sbps_pkg::ByteW-1:0]    reply_bytes[sbps_pkg::ReplyLen];
   logic [sbps_pkg::IdW-1:0]      found_cnt;

   int mismatch_count = 0;
   int beats_sent     = 0;
   int burst_left     = 0;
   int gap_max        = 4;
   int stall_pct      = 25;
   int hold_request   = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic queue_beat(input sbps_pkg::kind_type kind,
                             input logic [sbps_pkg::ByteW-1:0] tx, input logic present);
      scan_beat_type b;
      b.kind        = kind;
      b.tx_byte     = tx;
      b.servo_id    = cur_id;
      b.present     = present;
      b.found_count = found_cnt;
      b.last        = 1'b0;
      pending_beats.push_back(b);
   endtask

   task automatic queue_ping();
      logic [sbps_pkg::ByteW-1:0] chk;
      chk = ~(cur_id + sbps_pkg::PING_LEN + sbps_pkg::PING_INST);
      queue_beat(sbps_pkg::KIND_TX, sbps_pkg::HDR, 1'b0);
      queue_beat(sbps_pkg::KIND_TX, sbps_pkg::HDR, 1'b0);
      queue_beat(sbps_pkg::KIND_TX, cur_id, 1'b0);
      queue_beat(sbps_pkg::KIND_TX, sbps_pkg::PING_LEN, 1'b0);
      queue_beat(sbps_pkg::KIND_TX, sbps_pkg::PING_INST, 1'b0);
      queue_beat(sbps_pkg::KIND_TX, chk, 1'b0);
      reply_cnt   = '0;
      quiet_ticks = '0;
   endtask

   task automatic close_id(input logic ok);
      if (ok && found_cnt < sbps_pkg::FOUND_MAX)
         found_cnt++;
      queue_beat(sbps_pkg::KIND_OUTCOME, 8'h00, ok);
      if (cur_id < max_id_cfg) begin
         cur_id++;
         queue_ping();
      end else begin
         queue_beat(sbps_pkg::KIND_DONE, 8'h00, 1'b0);
         scanning    = 1'b0;
         reply_cnt   = '0;
         quiet_ticks = '0;
      end
   endtask

   task automatic scanner_predict(input logic [1:0] op, input logic [sbps_pkg::ByteW-1:0] b);
      int                         n_prior;
      logic [sbps_pkg::ByteW-1:0] sum;
      scan_beat_type              tail;
      n_prior = pending_beats.size();
      if (op == sbps_pkg::OP_START) begin
         if (!scanning) begin
            scanning  = 1'b1;
            cur_id    = '0;
            found_cnt = '0;
            queue_ping();
         end
      end else if (op == sbps_pkg::OP_TICK) begin
         if (scanning) begin
            if (quiet_ticks < sbps_pkg::QUIET_MAX)
               quiet_ticks++;
            if (quiet_ticks > {1'b0, timeout_cfg})
               close_id(1'b0);
         end
      end else if (op == sbps_pkg::OP_BYTE) begin
         if (scanning) begin
            quiet_ticks = '0;
            if (reply_cnt < sbps_pkg::REPLY_LAST) begin
               reply_bytes[reply_cnt] = b;
               reply_cnt++;
            end else begin
               sum = reply_bytes[2] + reply_bytes[3] + reply_bytes[4];
               close_id(reply_bytes[0] == sbps_pkg::HDR && reply_bytes[1] == sbps_pkg::HDR &&
                        reply_bytes[2] == cur_id && ~sum == b);
            end
         end
      end
      if (pending_beats.size() > n_prior) begin
         tail      = pending_beats.pop_back();
         tail.last = 1'b1;
         pending_beats.push_back(tail);
      end
   endtask

   task automatic send_beat(input logic [1:0] op, input logic [sbps_pkg::ByteW-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid   <= 1'b1;
      req_if.op      <= op;
      req_if.rx_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      beats_sent++;
      scanner_predict(op, b);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(sbps_pkg::OP_TICK, 8'($urandom));
   endtask

   // tick_max must not exceed the reply timeout, or the reply breaks up
   task automatic send_reply(input logic [sbps_pkg::IdW-1:0] id, input int nbytes,
                             input int flip_idx, input logic [sbps_pkg::ByteW-1:0] flip_mask,
                             input int tick_max);
      logic [sbps_pkg::ByteW-1:0] pkt[6];
      pkt[0] = sbps_pkg::HDR;
      pkt[1] = sbps_pkg::HDR;
      pkt[2] = id;
      pkt[3] = 8'($urandom);
      pkt[4] = 8'($urandom);
      pkt[5] = ~(pkt[2] + pkt[3] + pkt[4]);
      if (flip_idx < NO_FLIP)
         pkt[flip_idx] = pkt[flip_idx] ^ flip_mask;
      for (int i = 0; i < nbytes; i++) begin
         if (tick_max > 0)
            send_ticks($urandom_range(0, tick_max));
         send_beat(sbps_pkg::OP_BYTE, pkt[i]);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sbps_pkg::CsrIdxW-1:0] idx,
                            input logic [sbps_pkg::CsrDataW-1:0] val);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      if (idx == sbps_pkg::CSR_REPLY_TIMEOUT)
         timeout_cfg = val;
      else if (idx == sbps_pkg::CSR_MAX_ID)
         max_id_cfg = val[sbps_pkg::IdW-1:0];
   endtask

   task automatic set_scan(input int timeout, input int max_id);
      write_csr(sbps_pkg::CSR_REPLY_TIMEOUT, 16'(timeout));
      write_csr(sbps_pkg::CSR_MAX_ID, {8'($urandom), 8'(max_id)});
   endtask

   task automatic test_idle_inputs();
      send_beat(sbps_pkg::OP_TICK, 8'h00);
      send_beat(sbps_pkg::OP_BYTE, 8'hFF);
      send_beat(sbps_pkg::OP_BYTE, 8'h00);
      send_beat(OP_UNUSED, 8'hA5);
      wait_drained();
   endtask

   task automatic test_short_sweep();
      set_scan(3, 2);
      send_beat(sbps_pkg::OP_START, 8'h00);
      send_beat(sbps_pkg::OP_START, 8'hFF);
      send_beat(OP_UNUSED, 8'h5A);
      send_reply(cur_id, 6, NO_FLIP, 8'h00, 3);
      send_reply(cur_id, 6, 5, 8'hFF, 0);
      send_reply(cur_id, 2, NO_FLIP, 8'h00, 0);
      send_ticks(4);
      wait_drained();
   endtask

   task automatic test_min_settings();
      set_scan(1, 0);
      send_beat(sbps_pkg::OP_START, 8'h00);
      send_ticks(2);
      send_beat(sbps_pkg::OP_START, 8'h00);
      send_reply(cur_id, 6, NO_FLIP, 8'h00, 1);
      send_beat(sbps_pkg::OP_BYTE, 8'hFF);
      send_beat(sbps_pkg::OP_TICK, 8'hFF);
      wait_drained();
   endtask

   task automatic test_lower_max_id();
      set_scan(2, 9);
      send_beat(sbps_pkg::OP_START, 8'h00);
      send_reply(cur_id, 6, NO_FLIP, 8'h00, 1);
      send_ticks(3);
      write_csr(sbps_pkg::CSR_MAX_ID, {8'($urandom), 8'd1});
      write_csr(CSR_SPARE_2, 16'($urandom));
      write_csr(CSR_SPARE_3, 16'($urandom));
      send_reply(cur_id, 6, NO_FLIP, 8'h00, 2);
      wait_drained();
   endtask

   task automatic test_backpressure();
      set_scan(4, 6);
      gap_max = 0;
      send_beat(sbps_pkg::OP_START, 8'h00);
      hold_request = 300;
      repeat (6) send_reply(cur_id, 6, NO_FLIP, 8'h00, 0);
      gap_max = 4;
      while (scanning) send_ticks(5);
      wait_drained();
   endtask

   task automatic test_max_timeout();
      set_scan(65535, 1);
      gap_max   = 0;
      stall_pct = 0;
      send_beat(sbps_pkg::OP_START, 8'h00);
      send_ticks(12);
      send_reply(cur_id, 6, NO_FLIP, 8'h00, 2);
      send_reply(cur_id, 6, 2, 8'h01, 2);
      wait_drained();
      gap_max   = 4;
      stall_pct = 25;
   endtask

   task automatic test_full_sweep();
      set_scan(1, 12);
      stall_pct = 30;
      gap_max   = 3;
      send_beat(sbps_pkg::OP_START, 8'h00);
      while (scanning) begin
         if ($urandom_range(0, 7) == 0)
            send_reply(cur_id, 6, NO_FLIP, 8'h00, 1);
         else
            send_ticks(2);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int start_count;
      int pick;
      int tmax;
      start_count = beats_sent;
      while (beats_sent - start_count < RANDOM_ITEMS) begin
         set_scan(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 8),
                  $urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 60;
         endcase
         case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 2;
            default: gap_max = 6;
         endcase
         repeat ($urandom_range(0, 2))
            send_beat(2'($urandom_range(0, 3)) == sbps_pkg::OP_START ? sbps_pkg::OP_BYTE
                                                                      : 2'($urandom),
                      8'($urandom));
         send_beat(sbps_pkg::OP_START, 8'($urandom));
         tmax = (timeout_cfg < 3) ? int'(timeout_cfg) : 3;
         while (scanning) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
               send_reply(cur_id, 6, NO_FLIP, 8'h00, tmax);
            else if (pick < 70)
               send_reply(cur_id, 6, $urandom_range(0, 5), 8'($urandom_range(1, 255)), tmax);
            else if (pick < 82)
               send_ticks(int'(timeout_cfg) + 1);
            else if (pick < 92) begin
               send_reply(cur_id, $urandom_range(1, 5), NO_FLIP, 8'h00, tmax);
               send_ticks(int'(timeout_cfg) + 1);
            end else
               repeat ($urandom_range(1, 4)) send_beat(2'($urandom), 8'($urandom));
         end
      end
      wait_drained();
   endtask

   initial begin : rsp_stall
      int run_left;
      int hold;
      rsp_if.ready <= 1'b0;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
            rsp_if.ready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
            run_left = 0;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            run_left = $urandom_range(0, 5);
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      scan_beat_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected result beat", 16'(rsp_if.kind), 16'h0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_if.kind !== want.kind)
               report_mismatch("kind", 16'(rsp_if.kind), 16'(want.kind));
            if (rsp_if.tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", 16'(rsp_if.tx_byte), 16'(want.tx_byte));
            if (rsp_if.servo_id !== want.servo_id)
               report_mismatch("servo_id", 16'(rsp_if.servo_id), 16'(want.servo_id));
            if (rsp_if.present !== want.present)
               report_mismatch("present", 16'(rsp_if.present), 16'(want.present));
            if (rsp_if.found_count !== want.found_count)
               report_mismatch("found_count", 16'(rsp_if.found_count),
                               16'(want.found_count));
            if (rsp_if.last !== want.last)
               report_mismatch("last", 16'(rsp_if.last), 16'(want.last));
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
             (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : main_seq
      req_if.valid   <= 1'b0;
      req_if.op      <= sbps_pkg::OP_TICK;
      req_if.rx_byte <= 8'h00;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= sbps_pkg::CSR_REPLY_TIMEOUT;
      csr_if.data    <= 16'h0000;
      reset          <= 1'b1;
      timeout_cfg = sbps_pkg::TIMEOUT_RESET;
      max_id_cfg  = sbps_pkg::MAX_ID_RESET;
      scanning    = 1'b0;
      cur_id      = '0;
      reply_cnt   = '0;
      quiet_ticks = '0;
      found_cnt   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_inputs();
      test_short_sweep();
      test_min_settings();
      test_lower_max_id();
      test_backpressure();
      test_max_timeout();
      test_full_sweep();
      test_random_traffic();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_beats.size() != 0)
         report_mismatch("results never arrived", 16'(pending_beats.size()), 16'h0);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
